### rtl/syn_pkg.sv
// Shared types, constants and helper functions for the four-voice synthesizer.
// Depends on nothing; every other file in rtl/ imports it.
package syn_pkg;

  // Voice slot count and derived widths
  localparam int VOICES = 4;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int PHASE_W = 32;
  localparam int DUR_W   = 24;
  localparam int LEVEL_W = 15;
  localparam int NOISE_W = 9;
  localparam int PAN_W   = 9;
  localparam int SAMP_W  = 16;

  // Datapath widths
  localparam int PROD_W = LEVEL_W + DUR_W;          // level * remaining
  localparam int DCNT_W = $clog2(LEVEL_W + 1);      // divider step counter
  localparam int MIX_W  = 27;                       // 16s*10s + 16s*10s
  localparam int PANP_W = 26;                       // 16s * 10s pan product
  localparam int TERM_W = PANP_W - 7;               // pan product / 128
  localparam int ACC_W  = TERM_W + $clog2(VOICES + 1) + 1;

  // Constants
  localparam logic [PHASE_W-1:0] SEED_RESET = 32'h0064_d4a7;
  localparam int CLIP_MAX   = 32767;
  localparam int TRI_TOP    = 98303;
  localparam int TRI_HALF   = 32768;
  localparam int NOISE_FULL = 256;
  localparam int PAN_FULL   = 128;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_START_WR,
    ST_TICK_RD,
    ST_TICK_MIX,
    ST_TICK_DIV,
    ST_TICK_SCALE,
    ST_TICK_PAN,
    ST_TICK_ACC,
    ST_OUT
  } state_t;

  // One voice slot as stored in the voice RAM
  typedef struct packed {
    logic        [PHASE_W-1:0] phase;
    logic        [PHASE_W-1:0] incr;
    logic        [DUR_W-1:0]   remaining;
    logic        [DUR_W-1:0]   total;
    logic        [LEVEL_W-1:0] level;
    logic        [NOISE_W-1:0] noise;
    logic signed [PAN_W-1:0]   pan;
  } voice_t;

  // Voice RAM control group
  typedef struct packed {
    logic              clr;
    logic              wr_en;
    logic [VIDX_W-1:0] wr_addr;
    logic              rd_en;
    logic [VIDX_W-1:0] rd_addr;
  } ram_ctl_t;

  // One xorshift32 step
  function automatic logic [PHASE_W-1:0] xorshift32(input logic [PHASE_W-1:0] s);
    logic [PHASE_W-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

### rtl/four_voice_tone_noise_synth.sv
// Four-voice triangle/noise synthesizer top: command sequencer, voice datapath, output word.
// Tick: each slot is read and mixed; an active one also runs the level divider, scale, pan
//   and accumulate states; the output word loads once out_stall allows. One word in flight.
// Start: slot scan over every voice, then the write; clear: taken in the idle state.
// Reset: slot valid bits cleared (all voices silent), noise seed reloaded, no clearing pass.
// Depends on syn_pkg, syn_voice_ram and syn_level_div.
module four_voice_tone_noise_synth (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [syn_pkg::CMD_W-1:0]   in_command,
  input  logic        [syn_pkg::PHASE_W-1:0] in_phase_step,
  input  logic        [syn_pkg::DUR_W-1:0]   in_duration,
  input  logic        [syn_pkg::LEVEL_W-1:0] in_loudness,
  input  logic        [syn_pkg::NOISE_W-1:0] in_noise_weight,
  input  logic signed [syn_pkg::PAN_W-1:0]   in_balance,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [syn_pkg::SAMP_W-1:0]  out_left,
  output logic signed [syn_pkg::SAMP_W-1:0]  out_right
);
  import syn_pkg::*;

  state_t state_r, state_nxt;

  // Control registers
  logic [VIDX_W-1:0]  idx_r;
  logic [PHASE_W-1:0] seed_r;
  logic               out_valid_r;

  // Captured start word
  logic        [PHASE_W-1:0] inc_r;
  logic        [DUR_W-1:0]   dur_r;
  logic        [LEVEL_W-1:0] lvl_r;
  logic        [NOISE_W-1:0] nw_r;
  logic signed [PAN_W-1:0]   pan_r;

  // Slot scan
  logic [DUR_W-1:0]  best_rem_r;
  logic [VIDX_W-1:0] best_idx_r;

  // Voice datapath
  logic signed [SAMP_W-1:0] w_mix_r;
  logic signed [PAN_W-1:0]  ent_pan_r;
  logic signed [SAMP_W-1:0] scaled_r;
  logic signed [PANP_W-1:0] pl_prod_r;
  logic signed [PANP_W-1:0] pr_prod_r;
  logic signed [ACC_W-1:0]  acc_l_r;
  logic signed [ACC_W-1:0]  acc_rt_r;
  logic signed [SAMP_W-1:0] out_left_r;
  logic signed [SAMP_W-1:0] out_right_r;

  // Voice RAM and divider connections
  ram_ctl_t             ram_ctl;
  voice_t               wr_data;
  voice_t               rd_data;
  logic                 div_start;
  logic                 div_done;
  logic [LEVEL_W-1:0]   div_quot;

  // Combinational datapath
  logic                      in_acc;
  logic                      last_idx;
  logic                      active;
  logic                      out_free;
  logic        [PHASE_W-1:0] phase_new;
  logic        [SAMP_W-1:0]  wt;
  logic signed [SAMP_W+1:0]  wt2;
  logic signed [SAMP_W+1:0]  tri_w;
  logic signed [SAMP_W-1:0]  tri_s;
  logic signed [SAMP_W-1:0]  noise_s;
  logic signed [9:0]         nwt;
  logic signed [9:0]         nwt_inv;
  logic signed [MIX_W-1:0]   mix;
  logic        [PROD_W-1:0]  lvl_prod;
  logic signed [31:0]        scale_prod;
  logic signed [9:0]         pan_x;
  logic signed [TERM_W-1:0]  term_l;
  logic signed [TERM_W-1:0]  term_r;
  logic signed [PANP_W-1:0]  pl_adj;
  logic signed [PANP_W-1:0]  pr_adj;
  logic signed [SAMP_W-1:0]  clip_l;
  logic signed [SAMP_W-1:0]  clip_r;
  logic        [NOISE_W-1:0] nw_sat;
  logic signed [PAN_W-1:0]   pan_sat;
  logic        [DUR_W-1:0]   dur_fix;

  assign in_acc   = in_valid && !in_stall;
  assign last_idx = (idx_r == VIDX_W'(VOICES - 1));
  assign active   = (rd_data.remaining != '0);
  assign out_free = !out_valid_r || !out_stall;

  syn_voice_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ram_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  syn_level_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lvl_prod),
    .divisor  (rd_data.total),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Start word cleanup: saturate noise weight and pan, length zero becomes one
  always_comb begin
    nw_sat  = (in_noise_weight > NOISE_W'(NOISE_FULL)) ? NOISE_W'(NOISE_FULL)
                                                       : in_noise_weight;
    pan_sat = in_balance;
    if (in_balance < -PAN_W'(PAN_FULL)) begin
      pan_sat = -PAN_W'(PAN_FULL);
    end else if (in_balance > PAN_W'(PAN_FULL)) begin
      pan_sat = PAN_W'(PAN_FULL);
    end
    dur_fix = (in_duration == '0) ? DUR_W'(1) : in_duration;
  end

  // Oscillator, noise blend and envelope product from the slot just read
  always_comb begin
    phase_new = rd_data.phase + rd_data.incr;
    wt        = phase_new[PHASE_W-1:PHASE_W-SAMP_W];
    wt2       = signed'({1'b0, wt, 1'b0});
    tri_w     = wt[SAMP_W-1] ? ((SAMP_W+2)'(TRI_TOP) - wt2)
                             : (wt2 - (SAMP_W+2)'(TRI_HALF));
    tri_s     = tri_w[SAMP_W-1:0];
    noise_s   = signed'({~seed_r[SAMP_W-1], seed_r[SAMP_W-2:0]});
    nwt       = signed'({1'b0, rd_data.noise});
    nwt_inv   = 10'sd256 - nwt;
    mix       = MIX_W'(tri_s * nwt_inv) + MIX_W'(noise_s * nwt);
    lvl_prod  = PROD_W'(rd_data.level) * PROD_W'(rd_data.remaining);
  end

  // Level scaling, pan gains and truncating divide by 128
  always_comb begin
    scale_prod = w_mix_r * signed'({1'b0, div_quot});
    pan_x      = 10'(ent_pan_r);
    pl_adj     = pl_prod_r + (pl_prod_r[PANP_W-1] ? PANP_W'(PAN_FULL - 1) : '0);
    pr_adj     = pr_prod_r + (pr_prod_r[PANP_W-1] ? PANP_W'(PAN_FULL - 1) : '0);
    term_l     = pl_adj[PANP_W-1:7];
    term_r     = pr_adj[PANP_W-1:7];
  end

  // Output saturation
  always_comb begin
    if (acc_l_r < -ACC_W'(CLIP_MAX)) begin
      clip_l = -SAMP_W'(CLIP_MAX);
    end else if (acc_l_r > ACC_W'(CLIP_MAX)) begin
      clip_l = SAMP_W'(CLIP_MAX);
    end else begin
      clip_l = acc_l_r[SAMP_W-1:0];
    end
    if (acc_rt_r < -ACC_W'(CLIP_MAX)) begin
      clip_r = -SAMP_W'(CLIP_MAX);
    end else if (acc_rt_r > ACC_W'(CLIP_MAX)) begin
      clip_r = SAMP_W'(CLIP_MAX);
    end else begin
      clip_r = acc_rt_r[SAMP_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_TICK) begin
            state_nxt = ST_TICK_RD;
          end else if (in_command == CMD_START) begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: state_nxt = last_idx ? ST_START_WR : ST_SCAN_RD;
      ST_START_WR: state_nxt = ST_IDLE;
      ST_TICK_RD:  state_nxt = ST_TICK_MIX;
      ST_TICK_MIX: begin
        if (active) begin
          state_nxt = ST_TICK_DIV;
        end else begin
          state_nxt = last_idx ? ST_OUT : ST_TICK_RD;
        end
      end
      ST_TICK_DIV:   state_nxt = div_done ? ST_TICK_SCALE : ST_TICK_DIV;
      ST_TICK_SCALE: state_nxt = ST_TICK_PAN;
      ST_TICK_PAN:   state_nxt = ST_TICK_ACC;
      ST_TICK_ACC:   state_nxt = last_idx ? ST_OUT : ST_TICK_RD;
      ST_OUT:        state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, RAM control, divider start
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    ram_ctl.clr     = (state_r == ST_IDLE) && in_valid && (in_command == CMD_CLEAR);
    ram_ctl.rd_en   = (state_r == ST_SCAN_RD) || (state_r == ST_TICK_RD);
    ram_ctl.rd_addr = idx_r;
    ram_ctl.wr_en   = (state_r == ST_START_WR) || ((state_r == ST_TICK_MIX) && active);
    ram_ctl.wr_addr = (state_r == ST_START_WR) ? best_idx_r : idx_r;
    div_start       = (state_r == ST_TICK_MIX) && active;
    if (state_r == ST_START_WR) begin
      wr_data.phase     = '0;
      wr_data.incr      = inc_r;
      wr_data.remaining = dur_r;
      wr_data.total     = dur_r;
      wr_data.level     = lvl_r;
      wr_data.noise     = nw_r;
      wr_data.pan       = pan_r;
    end else begin
      wr_data           = rd_data;
      wr_data.phase     = phase_new;
      wr_data.remaining = rd_data.remaining - 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // in ST_OUT a new word replaces the one leaving
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (in_acc && (in_command == CMD_TICK)) begin
            seed_r <= xorshift32(seed_r);
          end
        end
        ST_SCAN_CMP: idx_r <= idx_r + 1'b1;
        ST_TICK_MIX: begin
          if (!active) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_TICK_ACC: idx_r <= idx_r + 1'b1;
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        inc_r    <= in_phase_step;
        dur_r    <= dur_fix;
        lvl_r    <= in_loudness;
        nw_r     <= nw_sat;
        pan_r    <= pan_sat;
        acc_l_r  <= '0;
        acc_rt_r <= '0;
      end
      ST_SCAN_CMP: begin
        if ((idx_r == '0) || (rd_data.remaining < best_rem_r)) begin
          best_rem_r <= rd_data.remaining;
          best_idx_r <= idx_r;
        end
      end
      ST_TICK_MIX: begin
        w_mix_r   <= mix[SAMP_W+7:8];
        ent_pan_r <= rd_data.pan;
      end
      ST_TICK_SCALE: scaled_r <= scale_prod[SAMP_W+14:15];
      ST_TICK_PAN: begin
        pl_prod_r <= scaled_r * (10'sd128 - pan_x);
        pr_prod_r <= scaled_r * (10'sd128 + pan_x);
      end
      ST_TICK_ACC: begin
        acc_l_r  <= acc_l_r + ACC_W'(term_l);
        acc_rt_r <= acc_rt_r + ACC_W'(term_r);
      end
      ST_OUT: begin
        if (out_free) begin
          out_left_r  <= clip_l;
          out_right_r <= clip_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

### rtl/syn_voice_ram.sv
// Voice slot RAM: one write port, one registered read port, per-slot valid bits.
// Slots not written since reset or the last clear read back as all zero. Uses syn_pkg.
module syn_voice_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  syn_pkg::ram_ctl_t ctl,
  input  syn_pkg::voice_t   wr_data,
  output syn_pkg::voice_t   rd_data
);
  import syn_pkg::*;

  voice_t            mem_r [VOICES];
  voice_t            rd_q_r;
  logic [VOICES-1:0] vld_r;
  logic              rd_vld_r;

  // Storage array and read data register
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem_r[ctl.rd_addr];
    end
  end

  // Valid bits: cleared at reset and by a clear, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[ctl.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### rtl/syn_level_div.sv
// Iterative divider for the envelope level: level*remaining / total, one bit a cycle.
// The quotient is known to fit LEVEL_W bits since remaining <= total. Uses syn_pkg.
module syn_level_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [syn_pkg::PROD_W-1:0]    dividend,
  input  logic [syn_pkg::DUR_W-1:0]     divisor,
  output logic                          done,
  output logic [syn_pkg::LEVEL_W-1:0]   quot
);
  import syn_pkg::*;

  logic [DUR_W-1:0]   rem_r;
  logic [LEVEL_W-1:0] low_r;
  logic [DUR_W-1:0]   div_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DUR_W:0]     trial;
  logic [DUR_W:0]     diff;
  logic               ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, low_r[LEVEL_W-1]};
    diff  = trial - {1'b0, div_r};
    ge    = !diff[DUR_W];
  end

  // Partial remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[PROD_W-1:LEVEL_W];
      low_r <= dividend[LEVEL_W-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      low_r <= {low_r[LEVEL_W-2:0], ge};
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(LEVEL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = low_r;

endmodule
